[design/tgr_pkg.sv]
// Shared types and constants for the text glyph row renderer.
// No dependencies; the top level, front end and back end import this package.
`timescale 1ns / 1ps

package tgr_pkg;

	// Field widths
	localparam int GDIM_W     = 5;   // glyph width / height
	localparam int CUR_W      = 13;  // cursor column / row
	localparam int SDIM_W     = 13;  // screen width / height
	localparam int PITCH_W    = 14;  // line stride in words
	localparam int WADDR_W    = 26;  // framebuffer word offset
	localparam int ROW_W      = 16;  // glyph row pixels
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_WORDS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 3'd4;

	localparam logic [7:0]       NEWLINE_CODE = 8'h0A;
	localparam logic [CUR_W-1:0] CURSOR_MAX   = 13'h1FFF;

	// Input word
	typedef struct packed {
		logic             cmd;
		logic [7:0]       char_code;
		logic [3:0]       glyph_row;
		logic [ROW_W-1:0] row_bits;
	} tgr_item_t;

	// Result word
	typedef struct packed {
		logic [WADDR_W-1:0] word_address;
		logic [ROW_W-1:0]   pixel_bits;
		logic [ROW_W-1:0]   visible_mask;
		logic               last;
	} tgr_result_t;

	// Configuration register file
	typedef struct packed {
		logic [SDIM_W-1:0]  screen_width;
		logic [SDIM_W-1:0]  screen_height;
		logic [PITCH_W-1:0] pitch_words;
		logic [GDIM_W-1:0]  glyph_width;
		logic [GDIM_W-1:0]  glyph_height;
	} tgr_cfg_t;

	// Command classes produced by the front end
	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_NEWLINE,
		KIND_PRINT
	} tgr_kind_t;

	// Queued command (store address travels alongside)
	typedef struct packed {
		tgr_kind_t        kind;
		logic             blank;     // glyph code outside the store
		logic [ROW_W-1:0] row_bits;
	} tgr_cmd_t;

	// Back end sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_ROWS
	} tgr_state_t;

endpackage

[design/text_glyph_row_renderer_unit.sv]
// Top level of the text glyph row renderer: configuration registers,
// front end and back end. Depends on tgr_pkg, tgr_front and tgr_back.
`timescale 1ns / 1ps

// Text console renderer with a loadable bitmap font.
// Input queue (push/full, item): load words (cmd 1) write one glyph row into
// the glyph store; print words (cmd 0) draw a character at the cursor, and
// code 10 is a newline that only moves the cursor.
// Result queue (empty/pop, result): one word per glyph row of a printed
// character, oldest first, with last set on the final row.
// Configuration: cfg_we writes cfg_data into register cfg_index in the same
// edge; write only while the block is idle.
// A print word waits in the command queue until the idle back end takes it
// for setup; it then issues one glyph row per cycle while the result queue
// has room, and takes no other command until its last row. Each row passes
// the store read and issue registers; loads and newlines act on dequeue.
// The back end sequencer, with one glyph store read port, sets this rate.
// A two-word command queue and a four-word result queue let the input side
// keep filling while results wait; when pop is held low, row issue stops
// once the result queue is full and full rises after two more words.
// Reset clears the cursor, both queues and the registers to their defaults;
// the glyph store holds no defined contents until loaded.

module text_glyph_row_renderer_unit
	import tgr_pkg::*;
#(
	parameter int MAX_GLYPH_WIDTH  = 16,
	parameter int MAX_GLYPH_HEIGHT = 16,
	parameter int GLYPH_COUNT      = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  tgr_item_t             item,
	output logic                  empty,
	input  logic                  pop,
	output tgr_result_t           result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int STORE_DEPTH = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
	localparam int AW          = $clog2(STORE_DEPTH);

	tgr_cfg_t      cfg_q;
	logic          head_valid;
	tgr_cmd_t      head;
	logic [AW-1:0] head_addr;
	logic          deq;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= SDIM_W'(1024);
			cfg_q.screen_height <= SDIM_W'(768);
			cfg_q.pitch_words   <= PITCH_W'(1024);
			cfg_q.glyph_width   <= GDIM_W'(8);
			cfg_q.glyph_height  <= GDIM_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[SDIM_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[SDIM_W-1:0];
				REG_PITCH_WORDS:   cfg_q.pitch_words   <= cfg_data[PITCH_W-1:0];
				REG_GLYPH_WIDTH:   cfg_q.glyph_width   <= cfg_data[GDIM_W-1:0];
				REG_GLYPH_HEIGHT:  cfg_q.glyph_height  <= cfg_data[GDIM_W-1:0];
				default: ;
			endcase
		end
	end

	tgr_front #(
		.GLYPH_COUNT     (GLYPH_COUNT),
		.MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT),
		.AW              (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.head_valid(head_valid),
		.head      (head),
		.head_addr (head_addr),
		.deq       (deq)
	);

	tgr_back #(
		.MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
		.MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT),
		.STORE_DEPTH     (STORE_DEPTH),
		.AW              (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(head_valid),
		.head      (head),
		.head_addr (head_addr),
		.deq       (deq),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

[design/tgr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tgr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/tgr_front.sv]
// Front end: classifies input words and queues them for the back end.
// Depends on tgr_pkg.
`timescale 1ns / 1ps

module tgr_front
	import tgr_pkg::*;
#(
	parameter int GLYPH_COUNT      = 256,
	parameter int MAX_GLYPH_HEIGHT = 16,
	parameter int AW               = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  tgr_item_t     item,
	output logic          head_valid,
	output tgr_cmd_t      head,
	output logic [AW-1:0] head_addr,
	input  logic          deq
);

	localparam int PRODW = 8 + $clog2(MAX_GLYPH_HEIGHT + 1);

	logic             in_store;
	logic             row_ok;
	logic             drop;
	logic             enq;
	logic [PRODW-1:0] glyph_base;
	tgr_cmd_t         cls;
	logic [AW-1:0]    cls_addr;

	tgr_cmd_t      q_cmd_q  [2];
	logic [AW-1:0] q_addr_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	// Classify the incoming word and form its store address
	always_comb begin
		in_store   = int'(item.char_code) < GLYPH_COUNT;
		row_ok     = int'(item.glyph_row) < MAX_GLYPH_HEIGHT;
		glyph_base = PRODW'(item.char_code) * PRODW'(MAX_GLYPH_HEIGHT);
		cls.row_bits = item.row_bits;
		cls.blank    = !in_store;
		if (item.cmd) begin
			cls.kind = KIND_LOAD;
			cls_addr = AW'(glyph_base + PRODW'(item.glyph_row));
		end else if (item.char_code == NEWLINE_CODE) begin
			cls.kind = KIND_NEWLINE;
			cls_addr = AW'(glyph_base);
		end else begin
			cls.kind = KIND_PRINT;
			cls_addr = AW'(glyph_base);
		end
		// loads outside the store are dropped here
		drop = item.cmd && !(in_store && row_ok);
	end

	assign full       = (cnt_q == 2'd2);
	assign enq        = push && !full && !drop;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = q_cmd_q[rp_q];
	assign head_addr  = q_addr_q[rp_q];

	// Two-entry command queue: pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) begin
				wp_q <= !wp_q;
			end
			if (deq) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(enq) - 2'(deq);
		end
	end

	// Command queue: storage
	always_ff @(posedge clk) begin
		if (enq) begin
			q_cmd_q[wp_q]  <= cls;
			q_addr_q[wp_q] <= cls_addr;
		end
	end

endmodule

[design/tgr_back.sv]
// Back end: runs queued loads, newlines and prints; owns the glyph store,
// the cursor and the result queue. Depends on tgr_pkg and tgr_ram.
`timescale 1ns / 1ps

module tgr_back
	import tgr_pkg::*;
#(
	parameter int MAX_GLYPH_WIDTH  = 16,
	parameter int MAX_GLYPH_HEIGHT = 16,
	parameter int STORE_DEPTH      = 4096,
	parameter int AW               = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tgr_cfg_t      cfg,
	input  logic          head_valid,
	input  tgr_cmd_t      head,
	input  logic [AW-1:0] head_addr,
	output logic          deq,
	output logic          empty,
	input  logic          pop,
	output tgr_result_t   result
);

	localparam int HI_W = (MAX_GLYPH_WIDTH < ROW_W) ? MAX_GLYPH_WIDTH : ROW_W;
	localparam int HI_H = (MAX_GLYPH_HEIGHT < ROW_W) ? MAX_GLYPH_HEIGHT : ROW_W;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PW    = $clog2(OQ_DEPTH);

	// Effective glyph size
	logic [GDIM_W-1:0] gw;
	logic [GDIM_W-1:0] gh;
	logic [ROW_W-1:0]  wmask;

	// Sequencer state
	tgr_state_t         state_q;
	tgr_state_t         state_d;
	logic [CUR_W-1:0]   col_q;
	logic [CUR_W-1:0]   row_q;
	logic [WADDR_W-1:0] base_q;
	logic [GDIM_W-1:0]  r_q;
	logic [AW-1:0]      src_q;
	logic               blank_q;
	logic [ROW_W-1:0]   colmask_q;

	// Row issue stage
	logic               valid_s1;
	logic [WADDR_W-1:0] addr_s1;
	logic [ROW_W-1:0]   vis_s1;
	logic               last_s1;
	logic               blank_s1;

	// Result queue
	tgr_result_t       oq_q [OQ_DEPTH];
	logic [OQ_PW-1:0]  oq_wp_q;
	logic [OQ_PW-1:0]  oq_rp_q;
	logic [OQ_PW:0]    oq_cnt_q;
	logic              oq_pop;
	tgr_result_t       oq_in;

	// Datapath nets
	logic                   space;
	logic                   issue;
	logic                   last_row;
	logic                   ram_we;
	logic [AW-1:0]          ram_raddr;
	logic [ROW_W-1:0]       ram_rdata;
	logic [CUR_W:0]         y;
	logic [ROW_W-1:0]       vis_now;
	logic [ROW_W-1:0]       colmask_d;
	logic [CUR_W+1:0]       col_off;
	logic [WADDR_W:0]       prod;
	logic [WADDR_W-1:0]     base_d;
	logic [CUR_W:0]         col_a;
	logic [CUR_W+1:0]       row_a;
	logic [CUR_W:0]         nl_sum;
	logic [CUR_W-1:0]       nl_row;

	// Clamp glyph dimensions and build the width mask
	always_comb begin
		if (cfg.glyph_width == '0) begin
			gw = GDIM_W'(1);
		end else if (cfg.glyph_width > GDIM_W'(HI_W)) begin
			gw = GDIM_W'(HI_W);
		end else begin
			gw = cfg.glyph_width;
		end
		if (cfg.glyph_height == '0) begin
			gh = GDIM_W'(1);
		end else if (cfg.glyph_height > GDIM_W'(HI_H)) begin
			gh = GDIM_W'(HI_H);
		end else begin
			gh = cfg.glyph_height;
		end
		for (int p = 0; p < ROW_W; p++) begin
			wmask[p] = GDIM_W'(p) < gw;
		end
	end

	// Per-character setup: column visibility and row-0 word offset
	always_comb begin
		col_off = '0;
		for (int p = 0; p < ROW_W; p++) begin
			// bit p holds pixel gw-1-p
			col_off = (CUR_W+2)'(col_q) + (CUR_W+2)'(gw) - (CUR_W+2)'(1)
				- (CUR_W+2)'(p);
			colmask_d[p] = (GDIM_W'(p) < gw) &&
				(col_off < (CUR_W+2)'(cfg.screen_width));
		end
		prod   = (WADDR_W+1)'(row_q) * (WADDR_W+1)'(cfg.pitch_words);
		base_d = WADDR_W'(prod + (WADDR_W+1)'(col_q));
	end

	// Cursor moves: advance after a character, and newline
	always_comb begin
		col_a = (CUR_W+1)'(col_q) + (CUR_W+1)'(gw);
		row_a = (CUR_W+2)'(row_q);
		if ((CUR_W+2)'(col_a) + (CUR_W+2)'(gw) > (CUR_W+2)'(cfg.screen_width)) begin
			col_a = '0;
			row_a = (CUR_W+2)'(row_q) + (CUR_W+2)'(gh);
		end
		if (row_a + (CUR_W+2)'(gh) > (CUR_W+2)'(cfg.screen_height)) begin
			row_a = '0;
			col_a = '0;
		end
		nl_sum = (CUR_W+1)'(row_q) + (CUR_W+1)'(gh);
		nl_row = (nl_sum > (CUR_W+1)'(CURSOR_MAX)) ? CURSOR_MAX : nl_sum[CUR_W-1:0];
	end

	// Row issue: room check and per-row fields
	always_comb begin
		space     = ((OQ_PW+1)'(oq_cnt_q) + (OQ_PW+1)'(valid_s1)) < (OQ_PW+1)'(OQ_DEPTH);
		issue     = (state_q == ST_ROWS) && space;
		last_row  = (r_q + GDIM_W'(1)) == gh;
		deq       = (state_q == ST_IDLE) && head_valid;
		ram_we    = deq && (head.kind == KIND_LOAD);
		ram_raddr = src_q + AW'(r_q);
		y         = (CUR_W+1)'(row_q) + (CUR_W+1)'(r_q);
		vis_now   = (y < (CUR_W+1)'(cfg.screen_height)) ? colmask_q : '0;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (deq && head.kind == KIND_PRINT) begin
					state_d = ST_ROWS;
				end
			end
			ST_ROWS: begin
				if (issue && last_row) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer registers and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			r_q     <= '0;
		end else begin
			state_q <= state_d;
			if (deq && head.kind == KIND_NEWLINE) begin
				col_q <= '0;
				row_q <= nl_row;
			end
			if (deq && head.kind == KIND_PRINT) begin
				r_q <= '0;
			end else if (issue) begin
				r_q <= r_q + GDIM_W'(1);
			end
			if (issue && last_row) begin
				col_q <= col_a[CUR_W-1:0];
				row_q <= row_a[CUR_W-1:0];
			end
		end
	end

	// Per-character payload
	always_ff @(posedge clk) begin
		if (deq && head.kind == KIND_PRINT) begin
			base_q    <= base_d;
			src_q     <= head_addr;
			blank_q   <= head.blank;
			colmask_q <= colmask_d;
		end else if (issue) begin
			base_q <= base_q + WADDR_W'(cfg.pitch_words);
		end
	end

	// Issue stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	// Issue stage payload, aligned with the store read data
	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1  <= base_q;
			vis_s1   <= vis_now;
			last_s1  <= last_row;
			blank_s1 <= blank_q;
		end
	end

	// Glyph store
	tgr_ram #(
		.WIDTH(ROW_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head_addr),
		.wdata(head.row_bits),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result word assembly
	always_comb begin
		oq_in.word_address = addr_s1;
		oq_in.pixel_bits   = blank_s1 ? '0 : (ram_rdata & wmask);
		oq_in.visible_mask = vis_s1;
		oq_in.last         = last_s1;
	end

	assign empty  = (oq_cnt_q == '0);
	assign oq_pop = pop && !empty;
	assign result = oq_q[oq_rp_q];

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q  <= '0;
			oq_rp_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				oq_wp_q <= oq_wp_q + OQ_PW'(1);
			end
			if (oq_pop) begin
				oq_rp_q <= oq_rp_q + OQ_PW'(1);
			end
			oq_cnt_q <= oq_cnt_q + (OQ_PW+1)'(valid_s1) - (OQ_PW+1)'(oq_pop);
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[oq_wp_q] <= oq_in;
		end
	end

endmodule

[tb/text_glyph_row_renderer_unit_test.sv]
// Self-checking testbench for text_glyph_row_renderer_unit: drives load, print and newline words
// through several screen geometries and checks every emitted glyph row against a predictor.
// Depends on tgr_pkg and the design files under design/.
`timescale 1ns / 1ps

module text_glyph_row_renderer_unit_test;
	import tgr_pkg::*;

	localparam logic CMD_PRINT     = 1'b0;
	localparam logic CMD_LOAD      = 1'b1;
	localparam int   FONT_DEPTH    = 4096;  // 256 glyphs x 16 rows
	localparam int   ROWS_PER_CODE = 16;
	localparam int   SETTLE_CYCLES = 40;    // covers loads and newlines still in flight
	localparam int   STALL_LIMIT   = 3000;

	// Glyph store, cursor and geometry shadow; queues the rows each print must produce
	class glyph_console_tracker;
		tgr_result_t      rows_due[$];
		logic [ROW_W-1:0] font [0:FONT_DEPTH-1];
		int unsigned      col, row;
		int unsigned      scr_w, scr_h, pitch, cfg_gw, cfg_gh;
		int               errors;

		function new();
			col    = 0;
			row    = 0;
			scr_w  = 1024;
			scr_h  = 768;
			pitch  = 1024;
			cfg_gw = 8;
			cfg_gh = 16;
			errors = 0;
		endfunction

		function int unsigned glyph_w();
			if (cfg_gw < 1) return 1;
			if (cfg_gw > 16) return 16;
			return cfg_gw;
		endfunction

		function int unsigned glyph_h();
			if (cfg_gh < 1) return 1;
			if (cfg_gh > 16) return 16;
			return cfg_gh;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SCREEN_WIDTH:  scr_w  = val[SDIM_W-1:0];
				REG_SCREEN_HEIGHT: scr_h  = val[SDIM_W-1:0];
				REG_PITCH_WORDS:   pitch  = val[PITCH_W-1:0];
				REG_GLYPH_WIDTH:   cfg_gw = val[GDIM_W-1:0];
				REG_GLYPH_HEIGHT:  cfg_gh = val[GDIM_W-1:0];
				default: ;
			endcase
		endfunction

		// Apply one accepted input word
		function void take_word(tgr_item_t w);
			int unsigned      gw, gh, y, r, c;
			logic [ROW_W-1:0] vis, wmask;
			tgr_result_t      e;
			gw    = glyph_w();
			gh    = glyph_h();
			wmask = ROW_W'((32'd1 << gw) - 32'd1);
			if (w.cmd == CMD_LOAD) begin
				font[{w.char_code, w.glyph_row}] = w.row_bits;
				return;
			end
			// newline: back to column 0, row saturates
			if (w.char_code == NEWLINE_CODE) begin
				col = 0;
				row = row + gh;
				if (row > CURSOR_MAX)
					row = CURSOR_MAX;
				return;
			end
			for (r = 0; r < gh; r++) begin
				y   = row + r;
				vis = '0;
				for (c = 0; c < gw; c++) begin
					if (col + c < scr_w && y < scr_h)
						vis[gw - 1 - c] = 1'b1;
				end
				e.word_address = WADDR_W'(y * pitch + col);
				e.pixel_bits   = font[w.char_code * ROWS_PER_CODE + r] & wmask;
				e.visible_mask = vis;
				e.last         = (r + 1 == gh);
				rows_due.push_back(e);
			end
			// advance, wrap right edge then bottom edge
			col = col + gw;
			if (col + gw > scr_w) begin
				col = 0;
				row = row + gh;
			end
			if (row + gh > scr_h) begin
				row = 0;
				col = 0;
			end
			col = col & 32'h1FFF;
			row = row & 32'h1FFF;
		endfunction

		// Compare one popped result word with the oldest expected row
		function void check_row(tgr_result_t got);
			tgr_result_t e;
			if (rows_due.size() == 0) begin
				$error("result word with none expected: %h", got);
				errors++;
				return;
			end
			e = rows_due.pop_front();
			if (got.word_address !== e.word_address) begin
				$error("word_address: expected %0d, got %0d", e.word_address, got.word_address);
				errors++;
			end
			if (got.pixel_bits !== e.pixel_bits) begin
				$error("pixel_bits: expected %h, got %h", e.pixel_bits, got.pixel_bits);
				errors++;
			end
			if (got.visible_mask !== e.visible_mask) begin
				$error("visible_mask: expected %b, got %b", e.visible_mask, got.visible_mask);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last: expected %b, got %b", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	tgr_item_t             item      = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	tgr_result_t           result;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	glyph_console_tracker console;
	bit                   glyph_ready [0:FONT_DEPTH-1];
	int unsigned          fill_code   = 65;
	int unsigned          words_sent  = 0;
	int                   idle_mode   = 0;  // 0 none, 1 sender, 2 receiver, 3 both
	int                   quiet_cycles = 0;

	text_glyph_row_renderer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int sender_gap_pct();
		if (idle_mode == 1) return 81;
		if (idle_mode == 3) return 24;
		return 0;
	endfunction

	function automatic int recv_stall_pct();
		if (idle_mode == 2) return 81;
		if (idle_mode == 3) return 24;
		return 0;
	endfunction

	// Result side: random pop stalls
	always @(negedge clk) begin
		pop <= ($urandom_range(0, 99) >= recv_stall_pct());
	end

	// Handshake monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				console.take_word(item);
			if (pop && !empty)
				console.check_row(result);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("text_glyph_row_renderer_unit regression: fail");
				$finish;
			end
		end
	end

	// First glyph row below gh not yet loaded, or -1 when the glyph is complete
	function automatic int missing_row(int unsigned code, int unsigned gh);
		int r;
		for (r = 0; r < gh; r++) begin
			if (!glyph_ready[code * ROWS_PER_CODE + r])
				return r;
		end
		return -1;
	endfunction

	// Offer one word; returns at the falling edge after it was taken.
	// push stays high, so unless a random sender gap is drawn the next word follows without a bubble.
	task automatic push_word(input tgr_item_t w);
		words_sent++;
		idle_mode = (words_sent / 20) % 4;
		while ($urandom_range(0, 99) < sender_gap_pct()) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= w;
		if (w.cmd == CMD_LOAD)
			glyph_ready[{w.char_code, w.glyph_row}] = 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_row(input logic [7:0] code, input logic [3:0] r,
			input logic [ROW_W-1:0] bits);
		tgr_item_t w;
		w.cmd       = CMD_LOAD;
		w.char_code = code;
		w.glyph_row = r;
		w.row_bits  = bits;
		push_word(w);
	endtask

	task automatic print_char(input logic [7:0] code);
		tgr_item_t w;
		w.cmd       = CMD_PRINT;
		w.char_code = code;
		w.glyph_row = 4'($urandom_range(0, 15));
		w.row_bits  = ROW_W'($urandom_range(0, 65535));
		push_word(w);
	endtask

	// Stop sending and wait until every expected row has come out
	task automatic drain();
		push <= 1'b0;
		while (console.rows_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		console.write_reg(idx, CFG_DATA_W'(val));
		@(negedge clk);
	endtask

	task automatic set_geometry(input int unsigned sw, input int unsigned sh,
			input int unsigned pw, input int unsigned gw, input int unsigned gh);
		put_reg(REG_SCREEN_WIDTH, sw);
		put_reg(REG_SCREEN_HEIGHT, sh);
		put_reg(REG_PITCH_WORDS, pw);
		put_reg(REG_GLYPH_WIDTH, gw);
		put_reg(REG_GLYPH_HEIGHT, gh);
		cfg_we <= 1'b0;
	endtask

	// Mostly complete glyphs followed by prints of them, plus stray loads and newlines
	task automatic run_random(input int count);
		int unsigned gh, pick, code;
		int          r, n;
		int unsigned ready[$];
		for (n = 0; n < count; n++) begin
			gh = console.glyph_h();
			ready.delete();
			for (code = 0; code < 256; code++) begin
				if (code != NEWLINE_CODE && missing_row(code, gh) < 0)
					ready.push_back(code);
			end
			pick = $urandom_range(0, 99);
			if (pick < 30 || ready.size() == 0) begin
				r = missing_row(fill_code, gh);
				if (r < 0 || fill_code == NEWLINE_CODE) begin
					fill_code = $urandom_range(0, 255);
					r = missing_row(fill_code, gh);
				end
				if (pick < 8 || r < 0)
					load_row(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
						ROW_W'($urandom_range(0, 65535)));
				else
					load_row(8'(fill_code), 4'(r), ROW_W'($urandom_range(0, 65535)));
			end else if (pick < 38) begin
				print_char(NEWLINE_CODE);
			end else begin
				print_char(8'(ready[$urandom_range(0, ready.size() - 1)]));
			end
		end
	endtask

	// Stimulus
	initial begin
		int r;
		console = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry: full glyph at the top code with extreme rows, a lone row at code 0
		for (r = 0; r < ROWS_PER_CODE; r++) begin
			if (r == 0)
				load_row(8'hFF, 4'(r), 16'hFFFF);
			else if (r == 15)
				load_row(8'hFF, 4'(r), 16'h0000);
			else
				load_row(8'hFF, 4'(r), r[0] ? 16'h5555 : 16'hAAAA);
		end
		load_row(8'h00, 4'd0, 16'h8000);
		print_char(8'hFF);
		print_char(NEWLINE_CODE);
		print_char(8'hFF);
		print_char(8'hFF);
		run_random(50);
		drain();

		// widest glyphs on a large screen; random traffic, a burst of newlines, then prints further down
		set_geometry(4096, 4096, 8192, 16, 16);
		run_random(25);
		drain();
		repeat (12)
			print_char(NEWLINE_CODE);
		print_char(NEWLINE_CODE);
		print_char(8'hFF);
		print_char(8'hFF);
		run_random(25);
		drain();

		// smallest geometry
		set_geometry(1, 1, 1, 1, 1);
		run_random(50);
		drain();

		// odd sizes, frequent wraps
		set_geometry(100, 40, 37, 7, 5);
		run_random(30);
		drain();
		run_random(30);
		drain();

		// glyph wider than the screen, partial visibility
		set_geometry(5, 3, 8192, 16, 4);
		run_random(50);
		drain();

		repeat (2) begin
			set_geometry($urandom_range(1, 160), $urandom_range(1, 120),
				$urandom_range(1, 8192), $urandom_range(1, 16), $urandom_range(1, 16));
			run_random(60);
			drain();
		end

		if (console.errors == 0)
			$display("text_glyph_row_renderer_unit regression: pass");
		else
			$display("text_glyph_row_renderer_unit regression: fail");
		$finish;
	end

endmodule

[text_glyph_row_renderer_unit.f]
design/tgr_pkg.sv
design/tgr_ram.sv
design/tgr_front.sv
design/tgr_back.sv
design/text_glyph_row_renderer_unit.sv
tb/text_glyph_row_renderer_unit_test.sv
